### rtl/core/fir_lp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fir_lp_pkg;

  // default build values
  localparam int TAPS_DEF        = 145;
  localparam int COEF_BITS_DEF   = 18;
  localparam int SAMPLE_BITS_DEF = 16;

  // coefficient table geometry (symmetric, first half stored)
  localparam int ROM_TAPS = 145;
  localparam int ROM_HALF = 73;
  localparam int ROM_FRAC = 17;

  localparam int HALF_ROM [ROM_HALF] = '{
    -2, -2, -3, -3, -2, -1, 2, 6, 11, 16,
    20, 23, 23, 19, 11, -2, -19, -38, -58, -75,
    -86, -87, -77, -54, -17, 31, 86, 143, 194, 230,
    243, 228, 180, 98, -11, -141, -278, -405, -504, -558,
    -551, -474, -325, -109, 157, 449, 734, 978, 1141, 1192,
    1105, 867, 483, -27, -622, -1247, -1833, -2303, -2579, -2593,
    -2287, -1628, -608, 752, 2401, 4258, 6221, 8172, 9988, 11549,
    12749, 13504, 13762
  };

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } fsm_e;

  // control from the sequencer to the mac unit
  typedef struct packed {
    logic clear;
    logic issue;
    logic live;
  } mac_ctl_t;

  // coefficient of tap k scaled to coef_bits-1 fraction bits
  function automatic int coef_at(input int k, input int coef_bits);
    logic [6:0] hidx;
    int         c;
    int         s;
    if (k >= ROM_TAPS) begin
      return 0;
    end
    hidx = (k < ROM_HALF) ? 7'(k) : 7'(ROM_TAPS - 1 - k);
    c    = HALF_ROM[hidx];
    if (coef_bits - 1 >= ROM_FRAC) begin
      return c <<< (coef_bits - 1 - ROM_FRAC);
    end
    s = ROM_FRAC - (coef_bits - 1);
    return (c + (1 <<< (s - 1))) >>> s;
  endfunction

endpackage

`default_nettype wire

### rtl/core/fir_lp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 145
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/core/fir_lp_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module fir_lp_mac #(
  parameter int TAPS        = fir_lp_pkg::TAPS_DEF,
  parameter int COEF_BITS   = fir_lp_pkg::COEF_BITS_DEF,
  parameter int SAMPLE_BITS = fir_lp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire fir_lp_pkg::mac_ctl_t         ctl_i,
  input  wire logic [$clog2(TAPS)-1:0]      tap_i,
  input  wire logic [SAMPLE_BITS-1:0]       rd_data_i,
  output logic                              busy_o,
  output logic      [SAMPLE_BITS-1:0]       y_o
);
  import fir_lp_pkg::*;

  localparam int PW = COEF_BITS + SAMPLE_BITS;
  localparam int AW = PW + $clog2(TAPS);
  localparam logic signed [AW-1:0] YMAX = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] YMIN = -YMAX - AW'(1);
  localparam logic signed [AW-1:0] RND  = AW'(64'sd1 <<< (COEF_BITS - 2));

  logic                          iss1_q, iss2_q, live1_q;
  logic signed [COEF_BITS-1:0]   coef1_q;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [PW-1:0]          prod_d, prod_q;
  logic signed [AW-1:0]          acc_d, acc_q;
  logic signed [AW-1:0]          rnd, shf;

  // stage 1: coefficient lookup alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss1_q <= 1'b0;
      iss2_q <= 1'b0;
    end else begin
      iss1_q <= ctl_i.issue;
      iss2_q <= iss1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    live1_q <= ctl_i.live;
    coef1_q <= COEF_BITS'(coef_at(int'(tap_i), COEF_BITS));
    prod_q  <= prod_d;
    acc_q   <= acc_d;
  end

  // stage 2: multiply, never-written entries read as zero
  assign smp    = live1_q ? $signed(rd_data_i) : '0;
  assign prod_d = coef1_q * smp;

  // stage 3: accumulate
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (iss2_q) begin
      acc_d = acc_q + {{(AW - PW){prod_q[PW-1]}}, prod_q};
    end
  end

  // round half up, then saturate
  assign rnd = acc_q + RND;
  assign shf = rnd >>> (COEF_BITS - 1);

  always_comb begin
    if (shf > YMAX) begin
      y_o = YMAX[SAMPLE_BITS-1:0];
    end else if (shf < YMIN) begin
      y_o = YMIN[SAMPLE_BITS-1:0];
    end else begin
      y_o = shf[SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = iss1_q | iss2_q;

  a_pipe_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss1_q |=> iss2_q) else $error("mac pipeline lost a tap");
  a_no_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |-> !(iss1_q || iss2_q)) else $error("accumulator cleared mid-walk");

endmodule

`default_nettype wire

### rtl/core/fir_lowpass_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// result path: item accept, tap walk, memory read with coefficient lookup, multiply,
//   accumulate, output register load; one item at a time, set by the single shared
//   multiply-accumulate walking one delay-line memory read per tap
// the next item is taken while a finished result waits in the output register
// reset: asynchronous, active low; delay line reads as zero until each slot is written,
//   tracked by the write pointer and a full flag, so no clearing pass is needed
module fir_lowpass_filter #(
  parameter int TAPS        = fir_lp_pkg::TAPS_DEF,
  parameter int COEF_BITS   = fir_lp_pkg::COEF_BITS_DEF,
  parameter int SAMPLE_BITS = fir_lp_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // sample_in
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // filtered_out
  output logic      [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import fir_lp_pkg::*;

  localparam int KW = $clog2(TAPS);
  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [KW-1:0] LAST = KW'(TAPS - 1);

  fsm_e                   state_q, state_d;
  logic [KW-1:0]          wp_q, wp_d, rd_q, rd_d, k_q, k_d;
  logic                   full_q, full_d;
  logic                   accept, issue, load, busy;
  logic [SAMPLE_BITS-1:0] rd_data, y, out_q;
  logic                   out_vld_q;
  mac_ctl_t               ctl;

  assign accept = s_axis_tvalid & s_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_RUN;
      ST_RUN:   if (k_q == LAST) state_d = ST_DRAIN;
      ST_DRAIN: if (!busy && (!out_vld_q || m_axis_tready)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load          = 1'b0;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_RUN:   issue = 1'b1;
      ST_DRAIN: load = !busy && (!out_vld_q || m_axis_tready);
      default:  ;
    endcase
  end

  // write pointer, read pointer and tap counter
  always_comb begin
    wp_d   = wp_q;
    full_d = full_q;
    rd_d   = rd_q;
    k_d    = k_q;
    if (accept) begin
      wp_d = (wp_q == LAST) ? '0 : wp_q + KW'(1);
      if (wp_q == LAST) full_d = 1'b1;
      rd_d = wp_q;
      k_d  = '0;
    end else if (issue) begin
      rd_d = (rd_q == '0) ? LAST : rd_q - KW'(1);
      k_d  = k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      full_q    <= 1'b0;
      rd_q      <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      full_q  <= full_d;
      rd_q    <= rd_d;
      k_q     <= k_d;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= y;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = DW'(out_q);

  // slot is live once written since reset
  assign ctl.clear = accept;
  assign ctl.issue = issue;
  assign ctl.live  = full_q || (rd_q < wp_q);

  fir_lp_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TAPS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .raddr_i (rd_q),
    .rdata_o (rd_data)
  );

  fir_lp_mac #(
    .TAPS        (TAPS),
    .COEF_BITS   (COEF_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .tap_i     (k_q),
    .rd_data_i (rd_data),
    .busy_o    (busy),
    .y_o       (y)
  );

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= LAST) else $error("write pointer out of range");
  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && k_q == LAST) |=> state_q == ST_DRAIN)
    else $error("tap walk overran");
  a_rise_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_DRAIN)
    else $error("result shown outside drain");
  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !busy) else $error("item taken with mac still busy");

endmodule

`default_nettype wire

### tb/sv/fir_output_checker.sv
`timescale 1ns / 1ps

// watches both streams, predicts each filtered output and compares in order
module fir_output_checker #(
  parameter int TAPS        = fir_lp_pkg::TAPS_DEF,
  parameter int COEF_BITS   = fir_lp_pkg::COEF_BITS_DEF,
  parameter int SAMPLE_BITS = fir_lp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  input  logic                                         in_ready_i,
  // sample_in
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]      in_data_i,
  input  logic                                         out_valid_i,
  input  logic                                         out_ready_i,
  // filtered_out
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]      out_data_i,
  output int                                           fail_count_o,
  output int                                           open_count_o,
  output int                                           results_seen_o
);
  import fir_lp_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

  // tap gains at coef_bits-1 fraction bits, zero past the table
  longint  tap_gain [TAPS];
  // sample history ring and slot of the newest sample
  sample_t history [TAPS];
  int      newest_slot;
  sample_t expected_out [$];
  int      mismatches;
  int      results_seen;
  sample_t got;
  sample_t want;

  initial begin
    longint w;
    for (int k = 0; k < TAPS; k++) begin
      w = (k < ROM_TAPS) ? HALF_ROM[(k < ROM_HALF) ? k : ROM_TAPS - 1 - k] : 0;
      if (COEF_BITS - 1 >= ROM_FRAC)
        tap_gain[k] = w <<< (COEF_BITS - 1 - ROM_FRAC);
      else
        tap_gain[k] = (w + (longint'(1) <<< (ROM_FRAC - COEF_BITS)))
                      >>> (ROM_FRAC + 1 - COEF_BITS);
    end
  end

  // convolution of the history with the taps, rounded half up and clamped
  function automatic sample_t lowpass_output();
    longint acc;
    longint y;
    acc = 0;
    for (int k = 0; k < TAPS; k++)
      acc += tap_gain[k] * longint'(history[(newest_slot + TAPS - k) % TAPS]);
    y = (acc + (longint'(1) <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
    if (y > SAT_HI) y = SAT_HI;
    if (y < SAT_LO) y = SAT_LO;
    return sample_t'(y);
  endfunction

  // predict on every accepted sample, compare on every accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (history[i]) history[i] = '0;
      newest_slot = 0;
      expected_out.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        history[newest_slot] = sample_t'(in_data_i[SAMPLE_BITS-1:0]);
        expected_out.push_back(lowpass_output());
        newest_slot = (newest_slot + 1) % TAPS;
      end
      if (out_valid_i && out_ready_i) begin
        got = sample_t'(out_data_i[SAMPLE_BITS-1:0]);
        results_seen++;
        if (expected_out.size() == 0) begin
          mismatches++;
          $display("%0t: filtered_out %0d arrived with nothing expected", $time, got);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: filtered_out expected %0d, actual %0d", $time, want, got);
          end
        end
      end
    end
    fail_count_o   <= mismatches;
    open_count_o   <= expected_out.size();
    results_seen_o <= results_seen;
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fir_lp_pkg::*;

  localparam int DATA_W    = ((SAMPLE_BITS_DEF + 7) / 8) * 8;
  localparam int LATENCY   = TAPS_DEF + 4;
  localparam int RUN_ITEMS = 550;
  localparam int QUIET_TAIL = 80;

  typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_t;

  function automatic int SAT_HI_VAL();
    return (1 <<< (SAMPLE_BITS_DEF - 1)) - 1;
  endfunction

  localparam sample_t S_MAX = sample_t'(SAT_HI_VAL());
  localparam sample_t S_MIN = sample_t'(-SAT_HI_VAL() - 1);

  // kinds of random stimulus segments
  typedef enum int {
    SEG_NOISE,
    SEG_SMALL,
    SEG_STEP,
    SEG_ALTERNATE,
    SEG_IMPULSE,
    SEG_PEAK
  } segment_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;

  logic quiet = 1'b0;
  int   idle_pct = 0;
  int   items_sent = 0;
  int   peak_runs = 0;
  int   fail_count;
  int   open_count;
  int   results_seen;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fir_lowpass_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  fir_output_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_i     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .out_valid_i    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_i     (m_axis_tdata),
    .fail_count_o   (fail_count),
    .open_count_o   (open_count),
    .results_seen_o (results_seen)
  );

  // offer one item, possibly after an idle burst, and wait for acceptance
  // nothing more is sent once the run has its full count of items
  task automatic send_sample(input sample_t value);
    if (items_sent >= RUN_ITEMS) return;
    quiet = (items_sent >= RUN_ITEMS - QUIET_TAIL);
    if (!quiet && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'(value);
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  // hold the sender off until every expected output has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
  endtask

  // receiver: ready in bursts with stalls between them, except in the quiet tail
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(40, 1)) @(posedge clk_i);
      if (!quiet) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(18, 1)) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    segment_e seg;
    int       seg_len;
    int       amp;
    int       v;
    bit       flip;
    bit       paused;
    sample_t  level;

    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, sign patterns, partial history after reset
    send_sample('0);
    repeat (3) send_sample(S_MAX);
    repeat (3) send_sample(S_MIN);
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(16'h5555));
    send_sample(sample_t'(16'haaaa));
    repeat (4) send_sample(S_MAX);
    repeat (4) send_sample('0);
    wait_drained();

    // random segments of structured content
    seg = SEG_PEAK;
    while (items_sent < RUN_ITEMS) begin
      idle_pct = $urandom_range(1) ? 35 : 0;
      seg_len  = $urandom_range(60, 10);
      level    = sample_t'($urandom);
      if (!paused && items_sent >= RUN_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      case (seg)
        SEG_NOISE: begin
          repeat (seg_len) send_sample(sample_t'($urandom));
        end
        SEG_SMALL: begin
          repeat (seg_len) send_sample(sample_t'(int'($urandom_range(512)) - 256));
        end
        SEG_STEP: begin
          repeat ($urandom_range(160, 20)) send_sample(level);
        end
        SEG_ALTERNATE: begin
          flip = $urandom_range(1);
          repeat (seg_len) begin
            send_sample(flip ? S_MIN : S_MAX);
            flip = !flip;
          end
        end
        SEG_IMPULSE: begin
          send_sample(level);
          repeat ($urandom_range(150, 10)) send_sample('0);
        end
        SEG_PEAK: begin
          // samples follow or oppose the tap signs so the sum is driven into clamping
          flip = $urandom_range(1);
          amp  = $urandom_range(SAT_HI_VAL() + 1, 20000);
          for (int j = 0; j < TAPS_DEF; j++) begin
            v = ((HALF_ROM[(j < ROM_HALF) ? j : ROM_TAPS - 1 - j] < 0) ^ flip) ? -amp : amp;
            if (v > SAT_HI_VAL()) v = SAT_HI_VAL();
            send_sample(sample_t'(v));
          end
          peak_runs++;
        end
        default: ;
      endcase
      seg = segment_e'($urandom_range(SEG_PEAK));
      if (seg == SEG_PEAK && peak_runs >= 3) seg = SEG_NOISE;
    end

    // drain and let the pipeline settle
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk_i);

    $display("sent %0d samples: extremes, full-scale and small noise, steps, impulses,",
             items_sent);
    $display("alternating extremes and %0d clamping runs; %0d outputs compared, %0d bad",
             peak_runs, results_seen, fail_count);
    if (fail_count == 0 && open_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/fir_lp_pkg.sv
rtl/core/fir_lp_ram.sv
rtl/core/fir_lp_mac.sv
rtl/core/fir_lowpass_filter.sv
tb/sv/fir_output_checker.sv
tb/sv/testbench.sv
